[rtl/core/bps_pkg.sv]
// Shared types, constants and the gamma table function of the Blinn-Phong pixel shader.
package bps_pkg;

  // Field widths
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned COEF_W = 16;

  // Default parameter values
  localparam int unsigned COLOR_BITS_DEF = 8;
  localparam int unsigned GAMMA_BITS_DEF = 10;

  // Vector formats: raw vectors into the normalizer, unit vectors in Q.15
  localparam int unsigned VEC_W = 18;
  localparam int unsigned UNIT_W = 17;
  localparam int unsigned ONE_Q15 = 32768;

  // Normalizer pipeline: square stage, one root bit per stage, one quotient
  // bit per stage, clamp/sign stage
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned NORM_LAT = SQRT_STEPS + DIV_STEPS + 2;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_X  = 3'd0,
    REG_LIGHT_Y  = 3'd1,
    REG_LIGHT_Z  = 3'd2,
    REG_SHINE    = 3'd3,
    REG_AMBIENT  = 3'd4,
    REG_DIFFUSE  = 3'd5,
    REG_SPECULAR = 3'd6
  } cfg_reg_e;

  // Register reset values
  localparam logic signed [FIELD_W-1:0] LIGHT_X_RST = -16'sd1024;
  localparam logic signed [FIELD_W-1:0] LIGHT_Y_RST = 16'sd1024;
  localparam logic signed [FIELD_W-1:0] LIGHT_Z_RST = -16'sd768;
  localparam logic [7:0] SHINE_RST = 8'd64;
  localparam logic [CFG_DATA_W-1:0] AMBIENT_RST = 48'h0000_3333_0000;
  localparam logic [CFG_DATA_W-1:0] DIFFUSE_RST = 48'h0000_8000_0000;
  localparam logic [CFG_DATA_W-1:0] SPECULAR_RST = 48'hCCCD_CCCD_CCCD;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] x;
    logic signed [UNIT_W-1:0] y;
    logic signed [UNIT_W-1:0] z;
  } unit_t;

  // Gamma 1/2.2 entry: largest c in [0, M] with (2c-1)^11 * 2^(5G) <= idx^5 * (2M)^11,
  // i.e. round(M * (idx/2^G)^(5/11)) with ties up, in exact integers
  function automatic int unsigned gamma_entry(int unsigned idx, int unsigned cbits,
                                              int unsigned gbits);
    logic [255:0] rhs;
    logic [255:0] lhs;
    int unsigned m;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    m = (1 << cbits) - 1;
    rhs = 256'd1;
    for (int t = 0; t < 5; t++) rhs = rhs * 256'(idx);
    for (int t = 0; t < 11; t++) rhs = rhs * 256'(2 * m);
    lo = 0;
    hi = m;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      lhs = 256'd1;
      for (int t = 0; t < 11; t++) lhs = lhs * 256'(2 * mid - 1);
      lhs = lhs << (5 * gbits);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

endpackage

[rtl/core/bps_if.sv]
// Pixel request and color result channel interfaces.
interface bps_in_if;
  logic valid;
  logic ready;
  logic signed [bps_pkg::FIELD_W-1:0] pos_x;
  logic signed [bps_pkg::FIELD_W-1:0] pos_y;
  logic signed [bps_pkg::FIELD_W-1:0] pos_z;
  logic signed [bps_pkg::FIELD_W-1:0] norm_x;
  logic signed [bps_pkg::FIELD_W-1:0] norm_y;
  logic signed [bps_pkg::FIELD_W-1:0] norm_z;

  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, output ready);
endinterface

interface bps_out_if #(
  parameter int unsigned COLOR_BITS = bps_pkg::COLOR_BITS_DEF
);
  logic valid;
  logic ready;
  logic [COLOR_BITS-1:0] red;
  logic [COLOR_BITS-1:0] green;
  logic [COLOR_BITS-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

[rtl/core/bps_norm.sv]
// Pipelined vector normalizer: squared length, bit-serial root, bit-serial divide.
module bps_norm (
  input  logic          clk_i,
  input  logic          en_i,
  input  bps_pkg::vec_t c_i,
  output bps_pkg::unit_t u_o,
  output logic          nz_o
);
  import bps_pkg::*;

  localparam int unsigned MAG_W = VEC_W - 1;
  localparam int unsigned SUM_W = 2 * MAG_W;
  localparam int unsigned FRAC = 30;
  localparam int unsigned RT_W = SUM_W + FRAC;
  localparam int unsigned LEN_W = 32;
  localparam int unsigned REM_W = MAG_W + FRAC;
  localparam int unsigned DV_W = LEN_W + DIV_STEPS;

  // Square stage inputs
  logic signed [VEC_W-1:0] cin [3];
  logic [MAG_W-1:0] mag_d [3];
  logic [SUM_W-1:0] sq_d [3];
  logic [SUM_W-1:0] ssum_d;

  // Root pipeline; index 0 is the square stage
  logic [RT_W-1:0]  x_q [SQRT_STEPS+1];
  logic [RT_W-1:0]  r_q [SQRT_STEPS+1];
  logic [MAG_W-1:0] smag_q [SQRT_STEPS+1][3];
  logic             sneg_q [SQRT_STEPS+1][3];
  logic             snz_q [SQRT_STEPS+1];

  // Divide pipeline
  logic [REM_W-1:0]     rem_q [DIV_STEPS][3];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS][3];
  logic [LEN_W-1:0]     len_q [DIV_STEPS];
  logic                 dneg_q [DIV_STEPS][3];
  logic                 dnz_q [DIV_STEPS];

  // Squared length
  always_comb begin
    cin[0] = c_i.x;
    cin[1] = c_i.y;
    cin[2] = c_i.z;
    ssum_d = '0;
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = cin[i][VEC_W-1] ? MAG_W'(-cin[i]) : MAG_W'(cin[i]);
      sq_d[i] = SUM_W'(mag_d[i]) * SUM_W'(mag_d[i]);
      ssum_d = ssum_d + sq_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= {ssum_d, FRAC'(0)};
      r_q[0] <= '0;
      snz_q[0] <= (ssum_d != '0);
      for (int i = 0; i < 3; i++) begin
        smag_q[0][i] <= mag_d[i];
        sneg_q[0][i] <= cin[i][VEC_W-1];
      end
    end
  end

  // Root: one result bit per stage, floor(sqrt(S * 2^30))
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [RT_W-1:0] BIT = RT_W'(1) << (RT_W - 2 - 2 * k);
    logic [RT_W-1:0] trial;
    assign trial = r_q[k] + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (x_q[k] >= trial) begin
          x_q[k+1] <= x_q[k] - trial;
          r_q[k+1] <= (r_q[k] >> 1) + BIT;
        end else begin
          x_q[k+1] <= x_q[k];
          r_q[k+1] <= r_q[k] >> 1;
        end
        snz_q[k+1] <= snz_q[k];
        for (int i = 0; i < 3; i++) begin
          smag_q[k+1][i] <= smag_q[k][i];
          sneg_q[k+1][i] <= sneg_q[k][i];
        end
      end
    end
  end

  // Divide: one quotient bit per stage, (mag << 30) / len per component
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int unsigned QB = DIV_STEPS - 1 - j;
    logic [REM_W-1:0]     rem_in [3];
    logic [DIV_STEPS-1:0] quo_in [3];
    logic                 neg_in [3];
    logic [LEN_W-1:0]     len_in;
    logic                 nz_in;
    logic [DV_W-1:0]      dv;

    if (j == 0) begin : g_first
      always_comb begin
        len_in = r_q[SQRT_STEPS][LEN_W-1:0];
        nz_in = snz_q[SQRT_STEPS];
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = REM_W'(smag_q[SQRT_STEPS][i]) << FRAC;
          quo_in[i] = '0;
          neg_in[i] = sneg_q[SQRT_STEPS][i];
        end
      end
    end else begin : g_next
      always_comb begin
        len_in = len_q[j-1];
        nz_in = dnz_q[j-1];
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = rem_q[j-1][i];
          quo_in[i] = quo_q[j-1][i];
          neg_in[i] = dneg_q[j-1][i];
        end
      end
    end

    assign dv = DV_W'(len_in) << QB;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[j] <= len_in;
        dnz_q[j] <= nz_in;
        for (int i = 0; i < 3; i++) begin
          dneg_q[j][i] <= neg_in[i];
          if (DV_W'(rem_in[i]) >= dv) begin
            rem_q[j][i] <= rem_in[i] - REM_W'(dv);
            quo_q[j][i] <= quo_in[i] | (DIV_STEPS'(1) << QB);
          end else begin
            rem_q[j][i] <= rem_in[i];
            quo_q[j][i] <= quo_in[i];
          end
        end
      end
    end
  end

  // Clamp to 1.0, apply sign, zero vector gives zero
  logic [DIV_STEPS-1:0] qc [3];
  logic signed [UNIT_W-1:0] u_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (quo_q[DIV_STEPS-1][i] > DIV_STEPS'(ONE_Q15)) ? DIV_STEPS'(ONE_Q15)
                                                           : quo_q[DIV_STEPS-1][i];
      if (!dnz_q[DIV_STEPS-1]) u_d[i] = '0;
      else if (dneg_q[DIV_STEPS-1][i]) u_d[i] = -$signed(UNIT_W'(qc[i]));
      else u_d[i] = $signed(UNIT_W'(qc[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_o.x <= u_d[0];
      u_o.y <= u_d[1];
      u_o.z <= u_d[2];
      nz_o <= dnz_q[DIV_STEPS-1];
    end
  end

endmodule

[rtl/core/blinn_phong_pixel_shader_top.sv]
// Blinn-Phong pixel shader top level: register file, shading pipeline, gamma lookup.
//
// Usage:
//   in_i carries one pixel request per handshake: world position (signed Q8.8)
//   and unnormalized normal (signed Q2.14). out_o returns one gamma-corrected
//   RGB triple per request, in request order.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   the pipeline is empty; indexes beyond the register map are ignored.
// Timing:
//   One request is accepted per clock while out_o is not stalled. Each request
//   passes through the three normalizers (N, L, V) and then the half-vector
//   normalizer, each of 51 stages (32 root bits, 17 quotient bits, square and
//   clamp stages), then the 16 multiply stages of the exponent, and then
//   shading and the two-level gamma table.
// Reset:
//   rst_ni clears all valid bits and loads the register defaults.
// Backpressure:
//   When out_o is stalled the whole pipeline holds; in_i.ready falls in the
//   same cycle, so nothing is dropped or repeated.
module blinn_phong_pixel_shader_top #(
  parameter int unsigned COLOR_BITS       = bps_pkg::COLOR_BITS_DEF,
  parameter int unsigned GAMMA_TABLE_BITS = bps_pkg::GAMMA_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bps_in_if.sink                          in_i,
  bps_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [bps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bps_pkg::*;

  // Pipeline stage map
  localparam int unsigned PWR_STEPS = 16;
  localparam int unsigned IDX_F = 2 * NORM_LAT + 3;
  localparam int unsigned LAT = IDX_F + PWR_STEPS + 5;
  localparam int unsigned DLY = NORM_LAT;
  localparam int unsigned DOT_W = 2 * UNIT_W + 2;

  // Gamma table split into groups read in two stages
  localparam int unsigned GAMMA_SIZE = (1 << GAMMA_TABLE_BITS) + 1;
  localparam int unsigned GRP_W = (GAMMA_TABLE_BITS > 8) ? 8 : GAMMA_TABLE_BITS;
  localparam int unsigned NG = (GAMMA_SIZE >> GRP_W) + 1;
  localparam int unsigned HI_W = GAMMA_TABLE_BITS + 1 - GRP_W;
  localparam int unsigned ROM_SPAN = NG << GRP_W;
  localparam int unsigned ROM_AW = $clog2(ROM_SPAN);
  localparam int unsigned IDX_W = GAMMA_TABLE_BITS + 1;

  typedef struct packed {
    unit_t       n;
    logic        nz;
    logic [15:0] dl;
  } dly_t;

  // Configuration registers
  logic signed [FIELD_W-1:0] light_x_q, light_y_q, light_z_q;
  logic [7:0] shine_q;
  logic [CFG_DATA_W-1:0] amb_q, dif_q, spc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q <= LIGHT_X_RST;
      light_y_q <= LIGHT_Y_RST;
      light_z_q <= LIGHT_Z_RST;
      shine_q <= SHINE_RST;
      amb_q <= AMBIENT_RST;
      dif_q <= DIFFUSE_RST;
      spc_q <= SPECULAR_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LIGHT_X:  light_x_q <= cfg_data_i[FIELD_W-1:0];
        REG_LIGHT_Y:  light_y_q <= cfg_data_i[FIELD_W-1:0];
        REG_LIGHT_Z:  light_z_q <= cfg_data_i[FIELD_W-1:0];
        REG_SHINE:    shine_q <= cfg_data_i[7:0];
        REG_AMBIENT:  amb_q <= cfg_data_i;
        REG_DIFFUSE:  dif_q <= cfg_data_i;
        REG_SPECULAR: spc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance and valid chain
  logic adv;
  logic [LAT-1:0] vld_q;

  assign adv = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready = adv;
  assign out_o.valid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // Positive dot product in Q.15, clamped to 1.0
  function automatic logic [15:0] dot_pos(logic signed [DOT_W-1:0] s);
    logic [DOT_W-1:0] t;
    t = DOT_W'(s) >> 15;
    if (s <= 0) return '0;
    else if (t > DOT_W'(ONE_Q15)) return 16'(ONE_Q15);
    else return t[15:0];
  endfunction

  // Stage A: raw normal, light and view vectors
  vec_t nin_q, lv_q, vv_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nin_q.x <= VEC_W'(in_i.norm_x);
      nin_q.y <= VEC_W'(in_i.norm_y);
      nin_q.z <= VEC_W'(in_i.norm_z);
      lv_q.x <= VEC_W'(light_x_q) - VEC_W'(in_i.pos_x);
      lv_q.y <= VEC_W'(light_y_q) - VEC_W'(in_i.pos_y);
      lv_q.z <= VEC_W'(light_z_q) - VEC_W'(in_i.pos_z);
      vv_q.x <= -VEC_W'(in_i.pos_x);
      vv_q.y <= -VEC_W'(in_i.pos_y);
      vv_q.z <= -VEC_W'(in_i.pos_z);
    end
  end

  // Normalizers for N, L and V
  unit_t n_u, l_u, v_u, h_u;
  logic n_nz, l_nz, v_nz, h_nz;

  bps_norm u_norm_n (.clk_i, .en_i(adv), .c_i(nin_q), .u_o(n_u), .nz_o(n_nz));
  bps_norm u_norm_l (.clk_i, .en_i(adv), .c_i(lv_q), .u_o(l_u), .nz_o(l_nz));
  bps_norm u_norm_v (.clk_i, .en_i(adv), .c_i(vv_q), .u_o(v_u), .nz_o(v_nz));

  // Stage B: half vector sum and N.L products
  vec_t hv_q;
  unit_t b_n_q;
  logic b_nz_q;
  logic signed [2*UNIT_W-1:0] nl_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hv_q.x <= VEC_W'(l_u.x) + VEC_W'(v_u.x);
      hv_q.y <= VEC_W'(l_u.y) + VEC_W'(v_u.y);
      hv_q.z <= VEC_W'(l_u.z) + VEC_W'(v_u.z);
      nl_q[0] <= (2*UNIT_W)'(n_u.x) * (2*UNIT_W)'(l_u.x);
      nl_q[1] <= (2*UNIT_W)'(n_u.y) * (2*UNIT_W)'(l_u.y);
      nl_q[2] <= (2*UNIT_W)'(n_u.z) * (2*UNIT_W)'(l_u.z);
      b_n_q <= n_u;
      b_nz_q <= n_nz;
    end
  end

  bps_norm u_norm_h (.clk_i, .en_i(adv), .c_i(hv_q), .u_o(h_u), .nz_o(h_nz));

  // Stage C and delay line: diffuse term waits for the half vector
  dly_t dly_q [DLY];
  dly_t c_d;

  always_comb begin
    c_d.n = b_n_q;
    c_d.nz = b_nz_q;
    c_d.dl = dot_pos(DOT_W'(nl_q[0]) + DOT_W'(nl_q[1]) + DOT_W'(nl_q[2]));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dly_q[0] <= c_d;
      for (int k = 1; k < DLY; k++) dly_q[k] <= dly_q[k-1];
    end
  end

  // Stage E: N.H products
  logic signed [2*UNIT_W-1:0] nh_q [3];
  logic [15:0] e_dl_q;
  logic e_nz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nh_q[0] <= (2*UNIT_W)'(dly_q[DLY-1].n.x) * (2*UNIT_W)'(h_u.x);
      nh_q[1] <= (2*UNIT_W)'(dly_q[DLY-1].n.y) * (2*UNIT_W)'(h_u.y);
      nh_q[2] <= (2*UNIT_W)'(dly_q[DLY-1].n.z) * (2*UNIT_W)'(h_u.z);
      e_dl_q <= dly_q[DLY-1].dl;
      e_nz_q <= dly_q[DLY-1].nz;
    end
  end

  // Stage F: N.H sum
  logic [15:0] f_dh_q, f_dl_q;
  logic f_hn_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_dh_q <= dot_pos(DOT_W'(nh_q[0]) + DOT_W'(nh_q[1]) + DOT_W'(nh_q[2]));
      f_dl_q <= e_dl_q;
      f_hn_q <= e_nz_q;
    end
  end

  // Power stages: square, then multiply when the exponent bit is set
  logic [15:0] pr_q [PWR_STEPS];
  logic [15:0] pd_q [PWR_STEPS];
  logic [15:0] pdl_q [PWR_STEPS];
  logic        phn_q [PWR_STEPS];

  for (genvar s = 0; s < PWR_STEPS; s++) begin : g_pow
    logic [15:0] r_in, d_in, dl_in;
    logic        hn_in;
    logic [31:0] prod;

    if (s == 0) begin : g_first
      assign r_in = 16'(ONE_Q15);
      assign d_in = f_dh_q;
      assign dl_in = f_dl_q;
      assign hn_in = f_hn_q;
    end else begin : g_next
      assign r_in = pr_q[s-1];
      assign d_in = pd_q[s-1];
      assign dl_in = pdl_q[s-1];
      assign hn_in = phn_q[s-1];
    end

    if (s % 2 == 0) begin : g_sq
      assign prod = 32'(r_in) * 32'(r_in);
    end else begin : g_mul
      assign prod = shine_q[7 - s/2] ? 32'(r_in) * 32'(d_in) : {1'b0, r_in, 15'd0};
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pr_q[s] <= prod[30:15];
        pd_q[s] <= d_in;
        pdl_q[s] <= dl_in;
        phn_q[s] <= hn_in;
      end
    end
  end

  // Stage G: coefficient products; no normal means ambient only
  logic [15:0] td_q [3];
  logic [15:0] ts_q [3];
  logic [15:0] g_dl, g_sp;
  logic [31:0] pdif [3];
  logic [31:0] pspc [3];

  always_comb begin
    g_dl = phn_q[PWR_STEPS-1] ? pdl_q[PWR_STEPS-1] : '0;
    g_sp = phn_q[PWR_STEPS-1] ? pr_q[PWR_STEPS-1] : '0;
    for (int ch = 0; ch < 3; ch++) begin
      pdif[ch] = 32'(dif_q[COEF_W*(2-ch) +: COEF_W]) * 32'(g_dl);
      pspc[ch] = 32'(spc_q[COEF_W*(2-ch) +: COEF_W]) * 32'(g_sp);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        td_q[ch] <= pdif[ch][30:15];
        ts_q[ch] <= pspc[ch][30:15];
      end
    end
  end

  // Stage H: channel sum, saturate, gamma index split
  logic [17:0] csum [3];
  logic [16:0] csat [3];
  logic [IDX_W-1:0] gidx [3];
  logic [HI_W-1:0] hi_q [3];
  logic [GRP_W-1:0] lo_q [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      csum[ch] = 18'(amb_q[COEF_W*(2-ch) +: COEF_W]) + 18'(td_q[ch]) + 18'(ts_q[ch]);
      csat[ch] = (csum[ch] > 18'd65536) ? 17'd65536 : csum[ch][16:0];
      gidx[ch] = IDX_W'(csat[ch] >> (16 - GAMMA_TABLE_BITS));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        hi_q[ch] <= gidx[ch][IDX_W-1:GRP_W];
        lo_q[ch] <= gidx[ch][GRP_W-1:0];
      end
    end
  end

  // Gamma table constants
  logic [COLOR_BITS-1:0] gamma_rom [ROM_SPAN];

  for (genvar e = 0; e < ROM_SPAN; e++) begin : g_rom
    localparam int unsigned GV = gamma_entry(e, COLOR_BITS, GAMMA_TABLE_BITS);
    assign gamma_rom[e] = COLOR_BITS'(GV);
  end

  // Table stage 1: one entry per group
  logic [COLOR_BITS-1:0] grp_q [3][NG];
  logic [HI_W-1:0] t_hi_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        t_hi_q[ch] <= hi_q[ch];
        for (int g = 0; g < NG; g++) begin
          grp_q[ch][g] <= gamma_rom[(ROM_AW'(g) << GRP_W) | ROM_AW'(lo_q[ch])];
        end
      end
    end
  end

  // Table stage 2: group select into the output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_o.red <= grp_q[0][t_hi_q[0]];
      out_o.green <= grp_q[1][t_hi_q[1]];
      out_o.blue <= grp_q[2][t_hi_q[2]];
    end
  end

`ifndef SYNTHESIS
  // A request in the last internal stage reaches the output on an advance
  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld_q[LAT-2] |=> out_o.valid)
    else $error("request lost before output register");

  // The valid chain freezes while the output is stalled
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("valid chain moved during stall");

  // The specular power never exceeds 1.0
  a_pow_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[IDX_F+PWR_STEPS] |-> pr_q[PWR_STEPS-1] <= 16'(ONE_Q15))
    else $error("specular power above one");

  // Diffuse and N.H terms stay within 1.0 after the delay line
  a_dl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[IDX_F] |-> f_dl_q <= 16'(ONE_Q15) && f_dh_q <= 16'(ONE_Q15))
    else $error("dot product above one");
`endif

endmodule

[bench/bps_shade_checker.sv]
// Checker for the Blinn-Phong pixel shader: color predictor, result queue and compare.
`timescale 1ns / 1ps
module bps_shade_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bps_in_if.sink                          px_mon,
  bps_out_if.sink                         col_mon,
  input  logic                            cfg_we_i,
  input  logic [bps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                              err_cnt_o,
  output int                              pending_o
);
  import bps_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  rgb_t            color_q[$];
  logic [7:0]      gamma_lut[0:1024];
  longint          lx, ly, lz;
  logic [7:0]      shine;
  logic [47:0]     amb, dif, spc;

  // Gamma table built once with exact integer arithmetic
  initial begin
    logic [255:0] rhs;
    logic [255:0] lhs;
    int lo, hi, mid;
    for (int i = 0; i <= 1024; i++) begin
      rhs = 256'd1;
      for (int t = 0; t < 5; t++) rhs = rhs * 256'(i);
      for (int t = 0; t < 11; t++) rhs = rhs * 256'd510;
      lo = 0;
      hi = 255;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = 256'd1;
        for (int t = 0; t < 11; t++) lhs = lhs * 256'(2 * mid - 1);
        lhs = lhs << 50;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      gamma_lut[i] = lo[7:0];
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // Unit vector in Q.15; returns 0 for the zero vector
  function automatic bit normalize(input longint c[3], output longint u[3]);
    longint unsigned s, len, mag, q;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(c[i] * c[i]);
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (s == 0) return 0;
    len = int_sqrt(s << 30);
    for (int i = 0; i < 3; i++) begin
      mag = c[i] < 0 ? -c[i] : c[i];
      q = (mag << 30) / len;
      if (q > ONE_Q15) q = ONE_Q15;
      u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic longint clamped_dot(longint a[3], longint b[3]);
    longint s;
    s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    if (s <= 0) return 0;
    s = s >>> 15;
    return s > ONE_Q15 ? ONE_Q15 : s;
  endfunction

  function automatic rgb_t shade_pixel(longint px, longint py, longint pz,
                                       longint nx, longint ny, longint nz);
    longint nraw[3], lraw[3], vraw[3], hraw[3];
    longint n[3], l[3], v[3], h[3];
    longint dl, sp, d, ka, kd, ks, sum;
    bit has_n, dummy;
    logic [7:0] ch[3];
    nraw = '{nx, ny, nz};
    lraw = '{lx - px, ly - py, lz - pz};
    vraw = '{-px, -py, -pz};
    has_n = normalize(nraw, n);
    dummy = normalize(lraw, l);
    dummy = normalize(vraw, v);
    for (int i = 0; i < 3; i++) hraw[i] = l[i] + v[i];
    dummy = normalize(hraw, h);
    dl = 0;
    sp = 0;
    if (has_n) begin
      dl = clamped_dot(n, l);
      d = clamped_dot(n, h);
      sp = ONE_Q15;
      for (int b = 7; b >= 0; b--) begin
        sp = (sp * sp) >>> 15;
        if (shine[b]) sp = (sp * d) >>> 15;
      end
    end
    for (int c = 0; c < 3; c++) begin
      ka = amb[32 - 16 * c +: 16];
      kd = dif[32 - 16 * c +: 16];
      ks = spc[32 - 16 * c +: 16];
      sum = ka + ((kd * dl) >>> 15) + ((ks * sp) >>> 15);
      if (sum > 65536) sum = 65536;
      ch[c] = gamma_lut[sum >> 6];
    end
    return '{ch[0], ch[1], ch[2]};
  endfunction

  // Register shadow, prediction on request, compare on result
  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t want;
    rgb_t got;
    if (!rst_ni) begin
      lx <= LIGHT_X_RST;
      ly <= LIGHT_Y_RST;
      lz <= LIGHT_Z_RST;
      shine <= SHINE_RST;
      amb <= AMBIENT_RST;
      dif <= DIFFUSE_RST;
      spc <= SPECULAR_RST;
      color_q.delete();
      err_cnt_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_LIGHT_X:  lx <= longint'($signed(cfg_data_i[15:0]));
          REG_LIGHT_Y:  ly <= longint'($signed(cfg_data_i[15:0]));
          REG_LIGHT_Z:  lz <= longint'($signed(cfg_data_i[15:0]));
          REG_SHINE:    shine <= cfg_data_i[7:0];
          REG_AMBIENT:  amb <= cfg_data_i;
          REG_DIFFUSE:  dif <= cfg_data_i;
          REG_SPECULAR: spc <= cfg_data_i;
          default: ;
        endcase
      end
      if (px_mon.valid && px_mon.ready)
        color_q.push_back(shade_pixel(px_mon.pos_x, px_mon.pos_y, px_mon.pos_z,
                                      px_mon.norm_x, px_mon.norm_y, px_mon.norm_z));
      if (col_mon.valid && col_mon.ready) begin
        got = '{col_mon.red, col_mon.green, col_mon.blue};
        if (color_q.size() == 0) begin
          if (err_cnt_o < 10) $display("color result with no request pending: %p", got);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          want = color_q.pop_front();
          if (want !== got) begin
            if (err_cnt_o < 10) $display("color mismatch: expected %p got %p", want, got);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = color_q.size();
endmodule

[bench/tb_blinn_phong_pixel_shader_top.sv]
// Testbench top: clock, reset, pixel stimulus, register setup and verdict.
`timescale 1ns / 1ps
module tb_blinn_phong_pixel_shader_top;
  import bps_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int LATENCY = 125;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int err_cnt, pending, idle_cycles;
  int send_idle_pct = 0;
  int stall_pct = 0;

  bps_in_if px_if();
  bps_out_if col_if();

  blinn_phong_pixel_shader_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(px_if.sink), .out_o(col_if.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  bps_shade_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .px_mon(px_if.sink), .col_mon(col_if.sink),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    px_if.valid = 1'b0;
    {px_if.pos_x, px_if.pos_y, px_if.pos_z} = '0;
    {px_if.norm_x, px_if.norm_y, px_if.norm_z} = '0;
    col_if.ready = 1'b0;
  end

  // Random receiver stall
  always @(posedge clk_i) col_if.ready <= ($urandom_range(99) >= stall_pct);

  // Watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((px_if.valid && px_if.ready) || (col_if.valid && col_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("blinn_phong_pixel_shader_top regression: fail");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Send one pixel request, holding until accepted; valid stays up for the next
  task automatic send_pixel(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                            logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
    while ($urandom_range(99) < send_idle_pct) begin
      px_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    px_if.valid <= 1'b1;
    px_if.pos_x <= px;
    px_if.pos_y <= py;
    px_if.pos_z <= pz;
    px_if.norm_x <= nx;
    px_if.norm_y <= ny;
    px_if.norm_z <= nz;
    do @(posedge clk_i); while (!px_if.ready);
  endtask

  // Drop valid and wait for every pending result
  task automatic drain();
    px_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // Mostly small scenes near the eye, some full-range noise
  task automatic random_pixel();
    logic [15:0] f[6];
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(3) == 0) f[i] = 16'($urandom);
      else f[i] = 16'($signed($urandom_range(4096)) - 2048) << $urandom_range(3);
    end
    if ($urandom_range(19) == 0) begin
      f[3] = '0;
      f[4] = '0;
      f[5] = '0;
    end
    send_pixel(f[0], f[1], f[2], f[3], f[4], f[5]);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes and the special cases at reset settings
    send_pixel(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pixel(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_pixel(16'h0100, 16'h0000, 16'h0200, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(-16'sd1024, 16'sd1024, -16'sd768, 16'h4000, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
    send_pixel(16'h0000, 16'h0000, -16'sd256, 16'h0000, 16'h0000, -16'sd16384);
    send_pixel(-16'sd512, 16'sd512, -16'sd384, -16'sd8000, 16'sd8000, -16'sd6000);
    send_pixel(16'hffff, 16'h0001, 16'h5555, 16'haaaa, 16'h0001, 16'hffff);
    // Sender waits for an empty pipeline
    drain();
    // L opposite to V: light mirrored through the pixel
    write_reg(REG_LIGHT_X, 48'(16'sd512));
    write_reg(REG_LIGHT_Y, 48'(16'sd0));
    write_reg(REG_LIGHT_Z, 48'(16'sd0));
    write_reg(REG_SHINE, 48'd0);
    send_pixel(16'sd256, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0);
    send_pixel(16'sd256, 16'sd256, 16'sd0, -16'sd16384, 16'sd100, 16'sd0);
    drain();
    write_reg(REG_SHINE, 48'd255);
    write_reg(REG_AMBIENT, 48'hffff_ffff_ffff);
    write_reg(REG_DIFFUSE, 48'hffff_ffff_ffff);
    write_reg(REG_SPECULAR, 48'hffff_ffff_ffff);
    send_pixel(16'sd256, 16'sd0, -16'sd256, -16'sd16384, 16'sd0, 16'sd16384);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

    // Random phases with varied settings and traffic pressure
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 75; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 75; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      write_reg(REG_LIGHT_X, 48'(ph == 4 ? 16'h8000 : 16'($urandom_range(4096)) - 16'd2048));
      write_reg(REG_LIGHT_Y, 48'(ph == 5 ? 16'h7fff : 16'($urandom_range(4096)) - 16'd2048));
      write_reg(REG_LIGHT_Z, 48'($urandom));
      write_reg(REG_SHINE, 48'(ph == 6 ? 1 : $urandom_range(255)));
      write_reg(REG_AMBIENT, ph == 7 ? 48'd0 : {16'($urandom_range(16384)),
                16'($urandom_range(16384)), 16'($urandom_range(16384))});
      write_reg(REG_DIFFUSE, {16'($urandom), 16'($urandom), 16'($urandom)});
      write_reg(REG_SPECULAR, {16'($urandom), 16'($urandom), 16'($urandom)});
      repeat (105) random_pixel();
    end
    send_idle_pct = 0;
    stall_pct = 0;
    drain();

    if (err_cnt == 0) $display("blinn_phong_pixel_shader_top regression: pass");
    else $display("blinn_phong_pixel_shader_top regression: fail");
    $finish;
  end
endmodule

[sim.f]
rtl/core/bps_pkg.sv
rtl/core/bps_if.sv
rtl/core/bps_norm.sv
rtl/core/blinn_phong_pixel_shader_top.sv
bench/bps_shade_checker.sv
bench/tb_blinn_phong_pixel_shader_top.sv
